// File: hdl/pm_sensor_frame_parser_macros.svh
// assertion macros for the particle sensor frame parser
`ifndef PM_SENSOR_FRAME_PARSER_MACROS_SVH
`define PM_SENSOR_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PMSFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PMSFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pmsfp_pkg.sv
// shared types and constants of the particle sensor frame parser
package pmsfp_pkg;

  localparam logic [7:0]  START_FIRST  = 8'h42;
  localparam logic [7:0]  START_SECOND = 8'h4D;
  localparam logic [15:0] LEN_SHORT    = 16'd20;
  localparam logic [15:0] LEN_LONG     = 16'd28;
  localparam int unsigned MAX_WORDS    = 12;
  localparam int unsigned SHORT_WORDS  = 8;
  localparam int unsigned IDX_W        = 4;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_OUT
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic byte_en;    // accepted byte, advance the frame parser
    logic rd_start;   // good frame: clear word counter, mark ok
    logic fail_load;  // bad checksum: load the failure result
    logic rd_en;      // read the current word from the payload store
    logic next_word;  // advance to the next word
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_end;  // incoming byte closes the frame
    logic sum_match;  // incoming byte completes a matching checksum
    logic last_word;  // result on the output is the last of its run
  } sts_t;

endpackage

// File: hdl/pmsfp_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pmsfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/pmsfp_ctrl.sv
// controller state machine of the particle sensor frame parser
module pmsfp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  pmsfp_pkg::sts_t sts_i,
  output pmsfp_pkg::cmd_t cmd_o
);

  pmsfp_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmsfp_pkg::ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      pmsfp_pkg::ST_RECV: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.byte_en = 1'b1;
          if (sts_i.frame_end) begin
            if (sts_i.sum_match) begin
              cmd_o.rd_start = 1'b1;
              state_d        = pmsfp_pkg::ST_READ;
            end else begin
              cmd_o.fail_load = 1'b1;
              state_d         = pmsfp_pkg::ST_OUT;
            end
          end
        end
      end
      pmsfp_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = pmsfp_pkg::ST_OUT;
      end
      pmsfp_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.last_word) begin
            state_d = pmsfp_pkg::ST_RECV;
          end else begin
            cmd_o.next_word = 1'b1;
            state_d         = pmsfp_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = pmsfp_pkg::ST_RECV;
      end
    endcase
  end

endmodule

// File: hdl/pmsfp_dpath.sv
// datapath of the particle sensor frame parser: position, sum, payload store
module pmsfp_dpath #(
  parameter int PayloadBytes = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     rx_byte_i,
  input  pmsfp_pkg::cmd_t                cmd_i,
  output pmsfp_pkg::sts_t                sts_o,
  output logic [pmsfp_pkg::IDX_W-1:0]    word_index_o,
  output logic [15:0]                    word_value_o,
  output logic                           checksum_ok_o,
  output logic                           last_o
);

  localparam int HalfDepth = (PayloadBytes + 1) / 2;
  localparam int AddrW     = $clog2(HalfDepth);
  localparam int PayWords  = PayloadBytes / 2;
  localparam int WordsLong =
    (PayWords < pmsfp_pkg::MAX_WORDS) ? PayWords : pmsfp_pkg::MAX_WORDS;
  localparam int WordsShort =
    (PayWords < pmsfp_pkg::SHORT_WORDS) ? PayWords : pmsfp_pkg::SHORT_WORDS;
  localparam logic [pmsfp_pkg::IDX_W-1:0] LastLong  = pmsfp_pkg::IDX_W'(WordsLong - 1);
  localparam logic [pmsfp_pkg::IDX_W-1:0] LastShort = pmsfp_pkg::IDX_W'(WordsShort - 1);

  logic [4:0]  pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  logic [pmsfp_pkg::IDX_W-1:0] cnt_q;
  logic        ok_q;

  logic [15:0] pos_ext;
  logic [15:0] sum_add;
  logic [15:0] len_lo;
  logic        is_chk_hi;
  logic        is_chk_lo;
  logic [4:0]  pay_idx;
  logic        pay_we;
  logic        we_even, we_odd;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]  rd_even, rd_odd;
  logic [pmsfp_pkg::IDX_W-1:0] last_idx;

  assign pos_ext   = {11'd0, pos_q};
  assign sum_add   = sum_q + {8'd0, rx_byte_i};
  assign len_lo    = {len_q[15:8], rx_byte_i};
  assign is_chk_hi = (pos_q > 5'd3) && (pos_ext == len_q + 16'd2);
  assign is_chk_lo = (pos_q > 5'd3) && (pos_ext == len_q + 16'd3);
  assign pay_idx   = pos_q - 5'd4;

  // byte-by-byte frame parsing
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    sum_d    = sum_q;
    chk_hi_d = chk_hi_q;
    pay_we   = 1'b0;
    if (cmd_i.byte_en) begin
      if (pos_q == 5'd0) begin
        if (rx_byte_i == pmsfp_pkg::START_FIRST) begin
          sum_d = {8'd0, rx_byte_i};
          pos_d = 5'd1;
        end
      end else if (pos_q == 5'd1) begin
        if (rx_byte_i == pmsfp_pkg::START_SECOND) begin
          sum_d = sum_add;
          pos_d = 5'd2;
        end else begin
          pos_d = 5'd0;
        end
      end else if (pos_q == 5'd2) begin
        sum_d = sum_add;
        len_d = {rx_byte_i, 8'd0};
        pos_d = 5'd3;
      end else if (pos_q == 5'd3) begin
        len_d = len_lo;
        if (len_lo == pmsfp_pkg::LEN_SHORT || len_lo == pmsfp_pkg::LEN_LONG) begin
          sum_d = sum_add;
          pos_d = 5'd4;
        end else begin
          pos_d = 5'd0;
        end
      end else if (is_chk_hi) begin
        chk_hi_d = rx_byte_i;
        pos_d    = pos_q + 5'd1;
      end else if (is_chk_lo) begin
        pos_d = 5'd0;
      end else begin
        sum_d  = sum_add;
        pay_we = ({1'b0, pay_idx} < 6'(PayloadBytes));
        pos_d  = pos_q + 5'd1;
      end
    end
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      chk_hi_q <= '0;
    end else begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      chk_hi_q <= chk_hi_d;
    end
  end

  // word counter and result kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ok_q  <= 1'b0;
    end else if (cmd_i.rd_start) begin
      cnt_q <= '0;
      ok_q  <= 1'b1;
    end else if (cmd_i.fail_load) begin
      cnt_q <= '0;
      ok_q  <= 1'b0;
    end else if (cmd_i.next_word) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // payload store split into even and odd byte banks
  assign we_even = pay_we && !pay_idx[0];
  assign we_odd  = pay_we && pay_idx[0];
  assign waddr   = AddrW'(pay_idx >> 1);
  assign raddr   = AddrW'(cnt_q);

  pmsfp_ram #(
    .Width (8),
    .Depth (HalfDepth)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_even)
  );

  pmsfp_ram #(
    .Width (8),
    .Depth (HalfDepth)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_odd)
  );

  // status and result fields
  assign last_idx = (len_q == pmsfp_pkg::LEN_LONG) ? LastLong : LastShort;

  assign sts_o.frame_end = is_chk_lo;
  assign sts_o.sum_match = (sum_q == {chk_hi_q, rx_byte_i});
  assign sts_o.last_word = !ok_q || (cnt_q == last_idx);

  assign word_index_o  = cnt_q;
  assign word_value_o  = ok_q ? {rd_even, rd_odd} : 16'd0;
  assign checksum_ok_o = ok_q;
  assign last_o        = sts_o.last_word;

endmodule

// File: hdl/pm_sensor_frame_parser.sv
// top level of the particle sensor serial frame parser
//
// Input channel: one received serial byte per transfer (rx_byte_i) under
// in_valid_i / in_stall_o. The parser hunts for 0x42 0x4D, takes a
// big-endian length of 20 or 28, sums all bytes before the checksum and
// stores the payload in two byte-wide rams (even and odd bytes).
// Output channel: word_index_o, word_value_o, checksum_ok_o, last_o under
// out_valid_o / out_stall_i.
// Bytes are taken one per cycle while a frame is being received. The
// transfer of the last checksum byte starts the result run: a good frame
// gives 8 or 12 words, each read from the rams in ST_READ and then shown
// in ST_OUT; a bad checksum gives one failure result in the cycle after
// that transfer. Input is stalled for the whole run. While out_stall_i is
// high the result holds and nothing advances.
// Reset returns the parser to hunting with a cleared sum; the payload
// rams are not cleared and need no clearing pass.
module pm_sensor_frame_parser #(
  parameter int PayloadBytes = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        checksum_ok_o,
  output logic        last_o
);

  `include "pm_sensor_frame_parser_macros.svh"

  pmsfp_pkg::cmd_t cmd;
  pmsfp_pkg::sts_t sts;

  // controller
  pmsfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  pmsfp_dpath #(
    .PayloadBytes (PayloadBytes)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .word_index_o  (word_index_o),
    .word_value_o  (word_value_o),
    .checksum_ok_o (checksum_ok_o),
    .last_o        (last_o)
  );

  // checks
  `PMSFP_ASSERT_NOW(a_stall_while_emit, out_valid_o, in_stall_o, "input open during result run")
  `PMSFP_ASSERT_NOW(a_fail_shape, out_valid_o && !checksum_ok_o, last_o && word_index_o == 4'd0 && word_value_o == 16'd0, "malformed failure result")
  `PMSFP_ASSERT_NOW(a_index_range, out_valid_o, word_index_o < 4'd12, "word index out of range")
  `PMSFP_ASSERT_NEXT(a_run_ends, out_valid_o && !out_stall_i && last_o, !out_valid_o && !in_stall_o, "run did not end after last")

endmodule

// File: verif/pm_sensor_frame_parser_checker.sv
// frame parser checker: predicts the result words from the accepted bytes and compares them
module pm_sensor_frame_parser_checker
  import pmsfp_pkg::*;
#(
  parameter int PayloadBytes = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  word_index_i,
  input  logic [15:0] word_value_i,
  input  logic        checksum_ok_i,
  input  logic        last_i,
  output int          error_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] value;
    logic        ok;
    logic        last;
  } frame_word_t;

  // parser state as the block should hold it
  logic [4:0]  frame_pos;
  logic [15:0] frame_len;
  logic [15:0] byte_sum;
  logic [15:0] rx_check;
  logic [7:0]  payload_mem [PayloadBytes];
  frame_word_t expected_words [$];

  // advance the frame parser by one received byte, queue the words it releases
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0] pos16;
    int          words;
    int          p;
    frame_word_t w;
    pos16 = {11'd0, frame_pos};
    if (frame_pos == 5'd0) begin
      // hunting for the first start byte
      if (b == START_FIRST) begin
        byte_sum  = {8'd0, b};
        frame_pos = 5'd1;
      end
    end else if (frame_pos == 5'd1) begin
      // a wrong second start byte is not retried as a first one
      if (b != START_SECOND) begin
        frame_pos = 5'd0;
      end else begin
        byte_sum  = byte_sum + b;
        frame_pos = 5'd2;
      end
    end else if (frame_pos == 5'd2) begin
      byte_sum  = byte_sum + b;
      frame_len = {b, 8'h00};
      frame_pos = 5'd3;
    end else if (frame_pos == 5'd3) begin
      frame_len[7:0] = b;
      if (frame_len != LEN_SHORT && frame_len != LEN_LONG) begin
        frame_pos = 5'd0;
      end else begin
        byte_sum  = byte_sum + b;
        frame_pos = 5'd4;
      end
    end else if (pos16 == frame_len + 16'd2) begin
      rx_check  = {b, 8'h00};
      frame_pos = frame_pos + 5'd1;
    end else if (pos16 == frame_len + 16'd3) begin
      // checksum complete: release the data words or one failure word
      rx_check[7:0] = b;
      if (byte_sum == rx_check) begin
        words = (int'(frame_len) - 4) / 2;
        if (words > PayloadBytes / 2) words = PayloadBytes / 2;
        if (words > int'(MAX_WORDS)) words = int'(MAX_WORDS);
        for (int i = 0; i < words; i++) begin
          w.index = i[3:0];
          w.value = {payload_mem[2 * i], payload_mem[2 * i + 1]};
          w.ok    = 1'b1;
          w.last  = (i == words - 1);
          expected_words.push_back(w);
        end
      end else begin
        w.index = '0;
        w.value = '0;
        w.ok    = 1'b0;
        w.last  = 1'b1;
        expected_words.push_back(w);
      end
      frame_pos = 5'd0;
    end else begin
      // payload: always summed, stored only while it fits
      byte_sum = byte_sum + b;
      p = int'(frame_pos) - 4;
      if (p < PayloadBytes) payload_mem[p] = b;
      frame_pos = frame_pos + 5'd1;
    end
  endtask

  // watch both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    frame_word_t w;
    if (!rst_ni) begin
      frame_pos = '0;
      frame_len = '0;
      byte_sum  = '0;
      rx_check  = '0;
      expected_words.delete();
      pending_o     = 0;
      error_count_o = 0;
    end else begin
      // byte transfer
      if (in_valid_i && !in_stall_i) parse_rx_byte(rx_byte_i);
      // result transfer against the oldest expected word
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result: word_index %0d word_value %h checksum_ok %b last %b",
                 word_index_i, word_value_i, checksum_ok_i, last_i);
          error_count_o++;
        end else begin
          w = expected_words.pop_front();
          if (word_index_i !== w.index) begin
            $error("word_index: expected %0d, got %0d", w.index, word_index_i);
            error_count_o++;
          end
          if (word_value_i !== w.value) begin
            $error("word_value: expected %h, got %h", w.value, word_value_i);
            error_count_o++;
          end
          if (checksum_ok_i !== w.ok) begin
            $error("checksum_ok: expected %b, got %b", w.ok, checksum_ok_i);
            error_count_o++;
          end
          if (last_i !== w.last) begin
            $error("last: expected %b, got %b", w.last, last_i);
            error_count_o++;
          end
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// File: verif/tb_pm_sensor_frame_parser.sv
// testbench top of the frame parser: byte stimulus, result stalls, watchdog and verdict
module tb_pm_sensor_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import pmsfp_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int RandomBytes = 190;
  localparam int MaxWait     = 18;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 40;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_ALTERNATE
  } fill_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  word_index_o;
  logic [15:0] word_value_o;
  logic        checksum_ok_o;
  logic        last_o;

  int          error_count;
  int          pending_words;
  int          idle_cycles;
  int          sent_bytes;
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  logic [7:0]  frame_bytes [$];

  pm_sensor_frame_parser u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .checksum_ok_o(checksum_ok_o),
    .last_o       (last_o)
  );

  pm_sensor_frame_parser_checker u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_i (word_index_o),
    .word_value_i (word_value_o),
    .checksum_ok_i(checksum_ok_o),
    .last_i       (last_o),
    .error_count_o(error_count),
    .pending_o    (pending_words)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("pm_sensor_frame_parser verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int stall_cycles;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall_cycles = rx_gaps_on ? $urandom_range(0, MaxWait) : 0;
      if (stall_cycles > 0) begin
        out_stall_i = 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // one byte transfer, with a random gap in front
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, MaxWait) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      rx_byte_i  = 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  // hold the byte side until every expected word has come out
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  // well-formed frame with a matching checksum
  task automatic build_frame(input logic [15:0] len, input fill_e fill);
    logic [15:0] sum;
    logic [7:0]  b;
    frame_bytes = {START_FIRST, START_SECOND, len[15:8], len[7:0]};
    sum = START_FIRST + START_SECOND + len[15:8] + len[7:0];
    for (int i = 0; i < int'(len) - 2; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_ALTERNATE: b = i[0] ? 8'h00 : 8'hFF;
        default: b = 8'($urandom);
      endcase
      frame_bytes.push_back(b);
      sum = sum + b;
    end
    frame_bytes.push_back(sum[15:8]);
    frame_bytes.push_back(sum[7:0]);
  endtask

  // a single bit flip behind the header always breaks the checksum
  task automatic corrupt_frame();
    int idx;
    idx = $urandom_range(4, frame_bytes.size() - 1);
    frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task automatic send_frame(input int count);
    for (int i = 0; i < count && i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
  endtask

  task automatic send_bad_header(input logic [7:0] second, input logic [15:0] len);
    frame_bytes = {START_FIRST, second, len[15:8], len[7:0]};
    send_frame(second == START_SECOND ? 4 : 2);
  endtask

  // stimulus and verdict
  initial begin
    int          kind;
    logic [15:0] len;
    fill_e       fill;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    rst_ni     = 1'b0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // hunting over stray bytes
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_SECOND);
    // wrong second start byte, the start byte itself is not retried
    send_bad_header(START_FIRST, 16'h0000);
    send_byte(START_SECOND);
    // lengths that are neither short nor long
    send_bad_header(START_SECOND, 16'h0015);
    send_bad_header(START_SECOND, 16'h0114);
    send_bad_header(START_SECOND, 16'hFFFF);
    // good short frame with extreme payload, long frame past the store, bad checksum
    build_frame(LEN_SHORT, FILL_ALTERNATE);
    send_frame(frame_bytes.size());
    build_frame(LEN_LONG, FILL_ONES);
    send_frame(frame_bytes.size());
    build_frame(LEN_LONG, FILL_ZERO);
    send_frame(frame_bytes.size());
    build_frame(LEN_SHORT, FILL_RANDOM);
    corrupt_frame();
    send_frame(frame_bytes.size());
    drain_results();

    // random frames, mostly well formed
    sent_bytes = 0;
    while (sent_bytes < RandomBytes) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) drain_results();
      len  = $urandom_range(0, 1) ? LEN_LONG : LEN_SHORT;
      fill = ($urandom_range(0, 7) == 0) ? fill_e'($urandom_range(1, 3)) : FILL_RANDOM;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_frame(len, fill);
        send_frame(frame_bytes.size());
      end else if (kind < 80) begin
        build_frame(len, fill);
        corrupt_frame();
        send_frame(frame_bytes.size());
      end else if (kind < 86) begin
        len = 16'($urandom);
        if (len == LEN_SHORT || len == LEN_LONG) len = len ^ 16'h0100;
        send_bad_header(START_SECOND, len);
      end else if (kind < 90) begin
        send_bad_header(8'($urandom_range(0, 255)) | 8'h01, 16'h0000);
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        // frame cut short, the next frame lands inside it
        build_frame(len, fill);
        send_frame($urandom_range(5, frame_bytes.size() - 1));
      end
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0 && pending_words == 0) begin
      $display("pm_sensor_frame_parser verification clean");
    end else begin
      $display("pm_sensor_frame_parser verification failed");
    end
    $finish;
  end

endmodule

// File: pm_sensor_frame_parser.f
+incdir+hdl
hdl/pmsfp_pkg.sv
hdl/pmsfp_ram.sv
hdl/pmsfp_ctrl.sv
hdl/pmsfp_dpath.sv
hdl/pm_sensor_frame_parser.sv
verif/pm_sensor_frame_parser_checker.sv
verif/tb_pm_sensor_frame_parser.sv
